>>> sv/sliding_window_median_filter_unit_defines.svh
// assertion helpers shared by the median filter rtl
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/swmf_pkg.sv
package swmf_pkg;

    // payload widths
    localparam int VALUE_W = 32;
    localparam int TS_W    = 32;

    // configuration register map
    localparam int WSIZE_W = 5;
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 5'd5;

    // apb data and address widths
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

endpackage

>>> sv/swmf_ram.sv
module swmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sliding_window_median_filter_unit.sv
// Sliding-window median filter. Each input transfer writes one timestamped Q16.16 sample
// into a ring of MAX_WINDOW entries; once the current sequence holds at least k samples
// (k = window_size, 0 read as 1, above MAX_WINDOW read as MAX_WINDOW) one result transfer
// follows, carrying the rank k/2+1 value of the last k samples and the timestamp of the
// sample at position k/2 counted from the oldest. The first k-1 samples of a sequence, and
// every sample after first_of_sequence until k are held again, give no result. The input
// is stalled while an item is being worked on: an item that gives a result is worked on by
// a single signed comparator that walks the value memory one entry per cycle for each
// candidate; an item that gives none goes back to idle after the start check. A finished
// result waits in the output register while the next sample is already taken. window_size
// sits at APB byte address 0; the user must write it only while idle, not checked by the block.
`include "sliding_window_median_filter_unit_defines.svh"

module sliding_window_median_filter_unit
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [TS_W-1:0]           i_sample_timestamp,
    input  logic signed [VALUE_W-1:0] i_sample_value,
    input  logic                      i_first_of_sequence,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [TS_W-1:0]           o_median_timestamp,
    output logic signed [VALUE_W-1:0] o_median_value,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > WSIZE_W) ? CW : WSIZE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_KEYR,
        S_KEY,
        S_CMP,
        S_EVAL,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [WSIZE_W-1:0]   r_window_size, n_window_size;
    logic [CW-1:0]        r_fill, n_fill;
    logic [AW-1:0]        r_wslot, n_wslot;
    logic [AW-1:0]        r_base, n_base;
    logic [AW-1:0]        r_ai, n_ai;
    logic [AW-1:0]        r_aj, n_aj;
    logic [AW-1:0]        r_taddr, n_taddr;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_less, n_less;
    logic [CW-1:0]        r_leq, n_leq;
    logic [VALUE_W-1:0]   r_ki, n_ki;
    logic                 r_out_valid, n_out_valid;
    logic [TS_W-1:0]      r_out_ts, n_out_ts;
    logic [VALUE_W-1:0]   r_out_val, n_out_val;

    logic                 w_in_acc;
    logic                 w_cfg_wr;
    logic [XW-1:0]        w_ws_x;
    logic [CW-1:0]        w_k;
    logic [CW-1:0]        w_target;
    logic [SW-1:0]        w_base_sum;
    logic [AW-1:0]        w_base;
    logic [SW-1:0]        w_taddr_sum;
    logic [AW-1:0]        w_taddr;
    logic [AW-1:0]        w_raddr;
    logic [VALUE_W-1:0]   w_vrdata;
    logic [TS_W-1:0]      w_trdata;
    logic                 w_lt;
    logic                 w_eq;
    logic                 w_found;

    // ring index step with wrap
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        if (a == AW'(MAX_WINDOW - 1)) begin
            res = '0;
        end else begin
            res = a + AW'(1);
        end
        return res;
    endfunction

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // effective window length
    always_comb begin
        w_ws_x = XW'(r_window_size);
        if (w_ws_x == '0) begin
            w_k = CW'(1);
        end else if (w_ws_x > XW'(MAX_WINDOW)) begin
            w_k = CW'(MAX_WINDOW);
        end else begin
            w_k = CW'(w_ws_x);
        end
    end

    assign w_target = w_k >> 1;

    // oldest slot of the window and slot of its middle sample
    assign w_base_sum  = SW'(r_wslot) + SW'(MAX_WINDOW) - SW'(w_k);
    assign w_base      = (w_base_sum >= SW'(MAX_WINDOW)) ?
                         AW'(w_base_sum - SW'(MAX_WINDOW)) : AW'(w_base_sum);
    assign w_taddr_sum = SW'(w_base) + SW'(w_target);
    assign w_taddr     = (w_taddr_sum >= SW'(MAX_WINDOW)) ?
                         AW'(w_taddr_sum - SW'(MAX_WINDOW)) : AW'(w_taddr_sum);

    // value memory read address: candidate in the key fetch, sweep otherwise
    assign w_raddr = (r_state == S_KEYR) ? r_ai : r_aj;

    // shared signed comparator
    assign w_lt = $signed(w_vrdata) < $signed(r_ki);
    assign w_eq = w_vrdata == r_ki;

    assign w_found = (r_less <= w_target) && (w_target < r_leq);

    swmf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_WINDOW)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wslot),
        .i_wdata (i_sample_value),
        .i_raddr (w_raddr),
        .o_rdata (w_vrdata)
    );

    swmf_ram #(
        .WIDTH (TS_W),
        .DEPTH (MAX_WINDOW)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wslot),
        .i_wdata (i_sample_timestamp),
        .i_raddr (r_taddr),
        .o_rdata (w_trdata)
    );

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_window_size = r_window_size;
        n_fill        = r_fill;
        n_wslot       = r_wslot;
        n_base        = r_base;
        n_ai          = r_ai;
        n_aj          = r_aj;
        n_taddr       = r_taddr;
        n_i           = r_i;
        n_j           = r_j;
        n_less        = r_less;
        n_leq         = r_leq;
        n_ki          = r_ki;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_ts      = r_out_ts;
        n_out_val     = r_out_val;

        // configuration write
        if (w_cfg_wr && (paddr[2] == REG_WINDOW_SIZE)) begin
            n_window_size = pwdata[WSIZE_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_wslot = ring_inc(r_wslot);
                    if (i_first_of_sequence) begin
                        n_fill = CW'(1);
                    end else if (r_fill < CW'(MAX_WINDOW)) begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_fill < w_k) begin
                    n_state = S_IDLE;
                end else begin
                    n_base  = w_base;
                    n_ai    = w_base;
                    n_taddr = w_taddr;
                    n_i     = '0;
                    n_state = S_KEYR;
                end
            end
            S_KEYR: begin
                n_aj    = r_base;
                n_state = S_KEY;
            end
            S_KEY: begin
                n_ki    = w_vrdata;
                n_aj    = ring_inc(r_aj);
                n_j     = CW'(1);
                n_less  = '0;
                n_leq   = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                // count entries below and not above the candidate
                if (w_lt) begin
                    n_less = r_less + CW'(1);
                end
                if (w_lt || w_eq) begin
                    n_leq = r_leq + CW'(1);
                end
                if (r_j == w_k) begin
                    n_state = S_EVAL;
                end else begin
                    n_aj = ring_inc(r_aj);
                    n_j  = r_j + CW'(1);
                end
            end
            S_EVAL: begin
                if (w_found || (r_i == w_k - CW'(1))) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_ai    = ring_inc(r_ai);
                    n_state = S_KEYR;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ts    = w_trdata;
                    n_out_val   = r_ki;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= WINDOW_SIZE_RESET;
            r_fill        <= '0;
            r_wslot       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_fill        <= n_fill;
            r_wslot       <= n_wslot;
            r_out_valid   <= n_out_valid;
        end
        r_base    <= n_base;
        r_ai      <= n_ai;
        r_aj      <= n_aj;
        r_taddr   <= n_taddr;
        r_i       <= n_i;
        r_j       <= n_j;
        r_less    <= n_less;
        r_leq     <= n_leq;
        r_ki      <= n_ki;
        r_out_ts  <= n_out_ts;
        r_out_val <= n_out_val;
    end

    // port drive
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_median_timestamp = r_out_ts;
    assign o_median_value     = $signed(r_out_val);
    assign pready             = 1'b1;
    assign prdata             = (paddr[2] == REG_WINDOW_SIZE) ?
                                APB_DATA_W'(r_window_size) : '0;

    // checks on the sequencer
    `SWMF_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == S_START, "accepted transfer did not start work")
    `SWMF_ASSERT_NOW(a_sweep_in_range, r_state == S_CMP, (r_j != '0) && (r_j <= w_k), "compare sweep index out of range")
    `SWMF_ASSERT_NOW(a_count_order, r_state == S_EVAL, r_leq > r_less, "candidate not counted against itself")
    `SWMF_ASSERT_NEXT(a_result_loaded, (r_state == S_DONE) && (!r_out_valid || !i_out_stall), o_out_valid, "finished result not presented")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import swmf_pkg::*;

    localparam int WINDOW_DEPTH = 16;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 20;
    localparam int ITEMS_PER_PHASE = 25;
    // register byte addresses on the apb port
    localparam logic [APB_ADDR_W-1:0] WSIZE_ADDR = APB_ADDR_W'(REG_WINDOW_SIZE) << 2;
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(1) << 2;

    typedef struct packed {
        logic [TS_W-1:0]           ts;
        logic signed [VALUE_W-1:0] value;
    } t_median;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [TS_W-1:0]           i_sample_timestamp;
    logic signed [VALUE_W-1:0] i_sample_value;
    logic                      i_first_of_sequence;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [TS_W-1:0]           o_median_timestamp;
    logic signed [VALUE_W-1:0] o_median_value;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // predicted filter state
    logic signed [VALUE_W-1:0] ring_vals [WINDOW_DEPTH];
    logic [TS_W-1:0]           ring_times [WINDOW_DEPTH];
    int                        held;
    int                        wr_slot;
    logic [WSIZE_W-1:0]        win_size;
    t_median                   pending_medians [$];

    // run bookkeeping
    int in_idle_pct;
    int out_stall_pct;
    int mismatch_count;
    int samples_sent;
    int medians_checked;
    int sizes_written;
    logic [TS_W-1:0] ts_clock;

    sliding_window_median_filter_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample_timestamp  (i_sample_timestamp),
        .i_sample_value      (i_sample_value),
        .i_first_of_sequence (i_first_of_sequence),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_median_timestamp  (o_median_timestamp),
        .o_median_value      (o_median_value),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // compare each result transfer with the oldest predicted median
    always @(posedge i_clk) begin : check_results
        t_median want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_medians.size() == 0) begin
                note_mismatch("unexpected result timestamp", '0, o_median_timestamp);
            end else begin
                want = pending_medians.pop_front();
                medians_checked++;
                if (o_median_timestamp !== want.ts)
                    note_mismatch("median timestamp", want.ts, o_median_timestamp);
                if (o_median_value !== want.value)
                    note_mismatch("median value", want.value, o_median_value);
            end
        end
    end

    // rank k/2+1 of the last k samples, tagged with the middle timestamp
    task automatic predict_median(input logic [TS_W-1:0] ts,
                                  input logic signed [VALUE_W-1:0] v, input logic restart);
        t_median res;
        logic signed [VALUE_W-1:0] win [WINDOW_DEPTH];
        logic signed [VALUE_W-1:0] tmp;
        int k;
        int base;
        int j2;
        if (restart)
            held = 0;
        ring_vals[wr_slot] = v;
        ring_times[wr_slot] = ts;
        wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
        if (held < WINDOW_DEPTH)
            held++;
        k = (win_size == 0) ? 1 : ((win_size > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(win_size));
        if (held >= k) begin
            base = wr_slot + WINDOW_DEPTH - k;
            for (int j = 0; j < k; j++)
                win[j] = ring_vals[(base + j) % WINDOW_DEPTH];
            // insertion sort, ascending signed order
            for (int i = 1; i < k; i++) begin
                tmp = win[i];
                j2 = i - 1;
                while (j2 >= 0 && win[j2] > tmp) begin
                    win[j2 + 1] = win[j2];
                    j2--;
                end
                win[j2 + 1] = tmp;
            end
            res.ts = ring_times[(base + k / 2) % WINDOW_DEPTH];
            res.value = win[k / 2];
            pending_medians.push_back(res);
        end
    endtask

    // one sample transfer; valid stays high afterwards unless the next call idles
    task automatic send_sample(input logic [TS_W-1:0] ts, input logic signed [VALUE_W-1:0] v,
                               input logic restart);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_timestamp <= ts;
        i_sample_value <= v;
        i_first_of_sequence <= restart;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        samples_sent++;
        predict_median(ts, v, restart);
    endtask

    // drop valid, let every predicted median arrive and the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_medians.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == WSIZE_ADDR) begin
            win_size = data[WSIZE_W-1:0];
            sizes_written++;
        end
    endtask

    // read back window_size and compare with the predicted register
    task automatic check_window_size();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= WSIZE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[WSIZE_W-1:0] !== win_size)
            note_mismatch("window_size read", 32'(win_size), 32'(prdata[WSIZE_W-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window_size(input logic [WSIZE_W-1:0] k);
        wait_drained();
        apb_write(WSIZE_ADDR, APB_DATA_W'(k));
        check_window_size();
    endtask

    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(9))
            0: draw_value = 32'sh8000_0000;
            1: draw_value = 32'sh7fff_ffff;
            // small pool so that ties are common
            2, 3, 4: draw_value = {16'($signed($urandom_range(6)) - 3), 16'h8000 & 16'($urandom)};
            default: draw_value = $urandom;
        endcase
    endfunction

    function automatic logic [TS_W-1:0] next_ts();
        if ($urandom_range(19) == 0)
            ts_clock = $urandom;
        else
            ts_clock = ts_clock + $urandom_range(1, 20);
        return ts_clock;
    endfunction

    // default size after reset, with the field extremes
    task automatic test_default_window();
        check_window_size();
        send_sample(32'h0000_0000, 32'sh8000_0000, 1'b1);
        send_sample(32'hffff_ffff, 32'sh7fff_ffff, 1'b0);
        send_sample(32'h0000_0001, 32'sh0000_0000, 1'b0);
        send_sample(32'h8000_0000, -32'sd1, 1'b0);
        send_sample(32'h7fff_ffff, 32'sh0001_0000, 1'b0);
        send_sample(32'h5555_aaaa, 32'sh8000_0000, 1'b0);
    endtask

    // size zero behaves as a window of one
    task automatic test_zero_window();
        set_window_size(5'd0);
        send_sample(32'haaaa_5555, 32'sh1234_5678, 1'b0);
        send_sample(32'h0000_0100, -32'sh0002_8000, 1'b0);
    endtask

    // sizes above the depth saturate to a full window
    task automatic test_oversize_window();
        set_window_size(5'd31);
        for (int i = 0; i < 8; i++)
            send_sample(32'h0000_1000 + i, $urandom, 1'b0);
    endtask

    // shrinking the window keeps the fill, so a result comes at once
    task automatic test_resize_mid_sequence();
        set_window_size(5'd3);
        send_sample(32'h0000_2000, 32'sh0003_0000, 1'b0);
    endtask

    // equal values resolved by rank
    task automatic test_equal_values();
        send_sample(32'h0000_3000, 32'sh0000_4000, 1'b0);
        send_sample(32'h0000_3001, 32'sh0000_4000, 1'b0);
        send_sample(32'h0000_3002, 32'sh0000_4000, 1'b0);
    endtask

    // a write outside the register map is ignored
    task automatic test_unmapped_register();
        wait_drained();
        apb_write(UNMAPPED_ADDR, 32'h0000_0001);
        check_window_size();
        send_sample(32'h0000_4000, -32'sh0000_4000, 1'b0);
    endtask

    // first_of_sequence empties the window
    task automatic test_sequence_restart();
        send_sample(32'h0000_5000, 32'sh0007_0000, 1'b1);
        send_sample(32'h0000_5001, -32'sh0007_0000, 1'b0);
        send_sample(32'h0000_5002, 32'sh0000_0001, 1'b0);
    endtask

    // random sequences over several sizes and idling patterns
    task automatic test_random_phases();
        int left;
        int seq_len;
        int k;
        logic [WSIZE_W-1:0] sz;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: sz = 5'd16;
                1: sz = 5'd0;
                2: sz = 5'd1;
                3: sz = 5'd31;
                default: begin
                    case ($urandom_range(9))
                        0: sz = 5'($urandom_range(17, 31));
                        1: sz = 5'($urandom_range(8, 16));
                        default: sz = 5'($urandom_range(2, 7));
                    endcase
                end
            endcase
            set_window_size(sz);
            case (phase % 4)
                0: begin in_idle_pct = 0; out_stall_pct = 0; end
                1: begin in_idle_pct = 78; out_stall_pct = 0; end
                2: begin in_idle_pct = 0; out_stall_pct = 78; end
                default: begin in_idle_pct = 7; out_stall_pct = 7; end
            endcase
            k = (sz == 0) ? 1 : ((sz > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(sz));
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                // mostly whole sequences, sometimes a short one or one with no restart
                seq_len = $urandom_range(1, k + 6);
                for (int i = 0; i < seq_len && left > 0; i++) begin
                    send_sample(next_ts(), draw_value(),
                                (i == 0) && ($urandom_range(9) < 8));
                    left--;
                end
            end
        end
        in_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample_timestamp <= '0;
        i_sample_value <= '0;
        i_first_of_sequence <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        held = 0;
        wr_slot = 0;
        win_size = WINDOW_SIZE_RESET;
        in_idle_pct = 0;
        out_stall_pct = 0;
        mismatch_count = 0;
        samples_sent = 0;
        medians_checked = 0;
        sizes_written = 0;
        ts_clock = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_zero_window();
        test_oversize_window();
        test_resize_mid_sequence();
        test_equal_values();
        test_unmapped_register();
        test_sequence_restart();
        test_random_phases();

        wait_drained();
        if (pending_medians.size() != 0)
            mismatch_count += pending_medians.size();
        $display("%0d samples sent across %0d window size writes, %0d medians checked",
                 samples_sent, sizes_written, medians_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
